@@ hdl/repeated_tone_burst_generator_assert.svh @@
// Assertion macros for the repeated tone burst generator.
// Expects signals named clock and reset in the including scope.
`ifndef REPEATED_TONE_BURST_GENERATOR_ASSERT_SVH
`define REPEATED_TONE_BURST_GENERATOR_ASSERT_SVH

// check cons in the same cycle as ante, outside reset
`define RTBG_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// check cons in the cycle after a reset cycle
`define RTBG_ASSERT_RESET(label, cons, msg) \
   label: assert property (@(posedge clock) reset |=> (cons)) else $error(msg);

`endif

@@ hdl/rtbg_pkg.sv @@
// Shared types and constants of the repeated tone burst generator.
// No dependencies.
`default_nettype none

package rtbg_pkg;

   localparam int unsigned CSR_INDEX_BITS = 3;
   localparam int unsigned CSR_DATA_BITS  = 32;
   localparam int unsigned SAMPLE_BITS    = 15;
   localparam int unsigned QUEUE_DEPTH    = 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_TONE_SAMPLES    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SILENCE_SAMPLES = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RAMP_SAMPLES    = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TONE_PHASE_STEP = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RAMP_PHASE_STEP = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REPEAT_TOTAL    = 3'd5;

   localparam logic [19:0] TONE_SAMPLES_RESET    = 20'd4800;
   localparam logic [19:0] SILENCE_SAMPLES_RESET = 20'd3840;
   localparam logic [15:0] RAMP_SAMPLES_RESET    = 16'd240;
   localparam logic [31:0] TONE_PHASE_STEP_RESET = 32'd89478485;
   localparam logic [31:0] RAMP_PHASE_STEP_RESET = 32'd8947849;
   localparam logic [7:0]  REPEAT_TOTAL_RESET    = 8'd1;

   localparam logic [14:0] AMPLITUDE = 15'd8192;

   localparam logic [1:0] ENV_FLAT = 2'd0;
   localparam logic [1:0] ENV_RISE = 2'd1;
   localparam logic [1:0] ENV_FALL = 2'd2;

   typedef struct packed {
      logic [19:0] tone_samples;
      logic [19:0] silence_samples;
      logic [15:0] ramp_samples;
      logic [31:0] tone_phase_step;
      logic [31:0] ramp_phase_step;
      logic [7:0]  repeat_total;
   } cfg_type;

   typedef struct packed {
      logic        tone;
      logic        done;
      logic [1:0]  env_mode;
      logic [31:0] tone_phase;
      logic [31:0] ramp_phase;
   } work_type;

endpackage

`default_nettype wire

@@ hdl/rtbg_if.sv @@
// Channel interfaces: sample tick requests, audio results, register writes.
// Depends on rtbg_pkg.
`default_nettype none

interface rtbg_req_if;
   logic valid;
   logic ready;
   logic active;
   logic restart;
   modport source (output valid, output active, output restart, input ready);
   modport sink (input valid, input active, input restart, output ready);
endinterface

interface rtbg_rsp_if import rtbg_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          done_res;
   modport source (output valid, output sample, output done_res, input ready);
   modport sink (input valid, input sample, input done_res, output ready);
endinterface

interface rtbg_csr_if import rtbg_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/repeated_tone_burst_generator.sv @@
// Repeated tone burst generator, top level: registers, sequencer, queue, datapath.
// Tone ticks step through datapath states S_ENV, S_SCALE and S_PROD, which share one cosine
// ROM port; no new tone tick is taken until the last is through. Silent ticks load the result
// register from the queue head and go through at one per cycle while results are taken.
// Reset: registers return to their defaults, counters and phases clear at once.
`default_nettype none
`include "repeated_tone_burst_generator_assert.svh"

module repeated_tone_burst_generator import rtbg_pkg::*; #(
   parameter int unsigned TABLE_ADDR_BITS = 10,
   parameter int unsigned COUNT_BITS      = 20
) (
   input  logic        clock,
   input  logic        reset,
   rtbg_req_if.sink    req_if,
   rtbg_rsp_if.source  rsp_if,
   rtbg_csr_if.sink    csr_if
);

   cfg_type  cfg;
   logic     q_push_valid, q_push_ready;
   work_type q_push_data;
   logic     q_pop_valid, q_pop_ready;
   work_type q_pop_data;

   rtbg_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg)
   );

   rtbg_front #(
      .COUNT_BITS (COUNT_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .cfg        (cfg),
      .push_valid (q_push_valid),
      .push_ready (q_push_ready),
      .push_data  (q_push_data)
   );

   rtbg_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push_valid),
      .push_ready (q_push_ready),
      .push_data  (q_push_data),
      .pop_valid  (q_pop_valid),
      .pop_ready  (q_pop_ready),
      .pop_data   (q_pop_data)
   );

   rtbg_back #(
      .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (q_pop_valid),
      .pop_ready (q_pop_ready),
      .pop_data  (q_pop_data),
      .rsp_if    (rsp_if)
   );

   `RTBG_ASSERT_NOW(a_pop_needs_item, q_pop_ready, q_pop_valid, "queue popped while empty")
   `RTBG_ASSERT_NOW(a_tone_not_done, q_pop_valid && q_pop_data.tone, !q_pop_data.done, "tone work marked done")
   `RTBG_ASSERT_NOW(a_done_is_silent, rsp_if.valid && rsp_if.done_res, rsp_if.sample == '0, "done result carries a nonzero sample")
   `RTBG_ASSERT_RESET(a_reset_empties, !rsp_if.valid && !q_pop_valid, "result or queue not empty after reset")

endmodule

`default_nettype wire

@@ hdl/rtbg_csr.sv @@
// Configuration registers of the tone burst generator.
// Depends on rtbg_pkg and rtbg_csr_if.
`default_nettype none

module rtbg_csr import rtbg_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   rtbg_csr_if.sink      csr_if,
   output cfg_type       cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_if.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         unique case (csr_if.index)
            CSR_TONE_SAMPLES:    cfg_in.tone_samples    = csr_if.data[19:0];
            CSR_SILENCE_SAMPLES: cfg_in.silence_samples = csr_if.data[19:0];
            CSR_RAMP_SAMPLES:    cfg_in.ramp_samples    = csr_if.data[15:0];
            CSR_TONE_PHASE_STEP: cfg_in.tone_phase_step = csr_if.data;
            CSR_RAMP_PHASE_STEP: cfg_in.ramp_phase_step = csr_if.data;
            CSR_REPEAT_TOTAL:    cfg_in.repeat_total    = csr_if.data[7:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tone_samples    <= TONE_SAMPLES_RESET;
         cfg_ff.silence_samples <= SILENCE_SAMPLES_RESET;
         cfg_ff.ramp_samples    <= RAMP_SAMPLES_RESET;
         cfg_ff.tone_phase_step <= TONE_PHASE_STEP_RESET;
         cfg_ff.ramp_phase_step <= RAMP_PHASE_STEP_RESET;
         cfg_ff.repeat_total    <= REPEAT_TOTAL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/rtbg_fifo.sv @@
// Short work queue between the tick sequencer and the sample datapath.
// Depends on rtbg_pkg.
`default_nettype none

module rtbg_fifo import rtbg_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  work_type push_data,
   output logic     pop_valid,
   input  logic     pop_ready,
   output work_type pop_data
);

   localparam int unsigned PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   work_type              slot_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  push, pop;

   assign push_ready = (count_ff != CNT_BITS'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

@@ hdl/rtbg_front.sv @@
// Tick sequencer: takes sample ticks, runs the burst counters and phases,
// and queues one work descriptor per tick. Depends on rtbg_pkg, rtbg_req_if.
`default_nettype none

module rtbg_front import rtbg_pkg::*; #(
   parameter int unsigned COUNT_BITS = 20
) (
   input  logic     clock,
   input  logic     reset,
   rtbg_req_if.sink req_if,
   input  cfg_type  cfg,
   output logic     push_valid,
   input  logic     push_ready,
   output work_type push_data
);

   localparam int unsigned SUM_BITS = ((COUNT_BITS > 20) ? COUNT_BITS : 20) + 1;

   logic                  in_valid_ff;
   logic                  in_active_ff;
   logic                  in_restart_ff;
   logic [COUNT_BITS-1:0] tone_count_ff, tone_count_in;
   logic [COUNT_BITS-1:0] silence_count_ff, silence_count_in;
   logic [7:0]            bursts_done_ff, bursts_done_in;
   logic [31:0]           tone_phase_ff, tone_phase_in;
   logic [31:0]           ramp_phase_ff, ramp_phase_in;
   logic [31:0]           fall_seed_ff, fall_seed_in;
   logic [16:0]           fall_offset;

   logic [COUNT_BITS-1:0] n_eff, sc_eff, sc_inc;
   logic [7:0]            bd_eff;
   logic [31:0]           tp_eff, rp_eff, ramp_used;
   logic [SUM_BITS-1:0]   n_ext, sc_ext, sc_inc_ext, t_ext, s_ext, r_ext, nr_ext;
   logic                  gen, accept, take;

   assign req_if.ready = !in_valid_ff || push_ready;
   assign accept       = req_if.valid && req_if.ready;
   assign take         = in_valid_ff && push_ready;
   assign push_valid   = in_valid_ff;

   // ramp phase on the first fall tick when the ramps overlap
   assign fall_offset  = {cfg.ramp_samples, 1'b0} - cfg.tone_samples[16:0];
   assign fall_seed_in = 32'(fall_offset * cfg.ramp_phase_step);

   assign n_eff  = in_restart_ff ? '0 : tone_count_ff;
   assign sc_eff = in_restart_ff ? '0 : silence_count_ff;
   assign bd_eff = in_restart_ff ? '0 : bursts_done_ff;
   assign tp_eff = in_restart_ff ? '0 : tone_phase_ff;
   assign rp_eff = in_restart_ff ? '0 : ramp_phase_ff;
   assign sc_inc = sc_eff + 1'b1;

   assign n_ext      = SUM_BITS'(n_eff);
   assign sc_ext     = SUM_BITS'(sc_eff);
   assign sc_inc_ext = SUM_BITS'(sc_inc);
   assign t_ext      = SUM_BITS'(cfg.tone_samples);
   assign s_ext      = SUM_BITS'(cfg.silence_samples);
   assign r_ext      = SUM_BITS'(cfg.ramp_samples);
   assign nr_ext     = n_ext + r_ext;
   assign gen        = (bd_eff < cfg.repeat_total) && in_active_ff;

   always_comb begin
      tone_count_in    = n_eff;
      silence_count_in = sc_eff;
      bursts_done_in   = bd_eff;
      tone_phase_in    = tp_eff;
      ramp_phase_in    = rp_eff;
      ramp_used        = rp_eff;
      push_data        = '0;
      if (gen) begin
         if (n_ext < t_ext) begin
            push_data.tone = 1'b1;
            if (n_ext < r_ext) begin
               push_data.env_mode = ENV_RISE;
            end else if (nr_ext >= t_ext) begin
               push_data.env_mode = ENV_FALL;
               if (nr_ext == t_ext) begin
                  ramp_used = '0;
               end else if (n_ext == r_ext) begin
                  ramp_used = fall_seed_ff;
               end
            end else begin
               push_data.env_mode = ENV_FLAT;
            end
            push_data.tone_phase = tp_eff;
            push_data.ramp_phase = ramp_used;
            ramp_phase_in        = ramp_used + cfg.ramp_phase_step;
            tone_phase_in        = tp_eff + cfg.tone_phase_step;
            tone_count_in        = n_eff + 1'b1;
         end else if (sc_ext < s_ext) begin
            silence_count_in = sc_inc;
            if (sc_inc_ext == s_ext) begin
               tone_count_in    = '0;
               silence_count_in = '0;
               tone_phase_in    = '0;
               ramp_phase_in    = '0;
               bursts_done_in   = bd_eff + 1'b1;
            end
         end
      end else begin
         push_data.done = (bd_eff == cfg.repeat_total);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         tone_count_ff    <= '0;
         silence_count_ff <= '0;
         bursts_done_ff   <= '0;
         tone_phase_ff    <= '0;
         ramp_phase_ff    <= '0;
      end else begin
         if (accept) begin
            in_valid_ff <= 1'b1;
         end else if (take) begin
            in_valid_ff <= 1'b0;
         end
         if (take) begin
            tone_count_ff    <= tone_count_in;
            silence_count_ff <= silence_count_in;
            bursts_done_ff   <= bursts_done_in;
            tone_phase_ff    <= tone_phase_in;
            ramp_phase_ff    <= ramp_phase_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      fall_seed_ff <= fall_seed_in;
      if (accept) begin
         in_active_ff  <= req_if.active;
         in_restart_ff <= req_if.restart;
      end
   end

endmodule

`default_nettype wire

@@ hdl/rtbg_back.sv @@
// Sample datapath: cosine ROM lookups, Hann envelope, scaling and
// saturation into the result register. Depends on rtbg_pkg, rtbg_rsp_if.
`default_nettype none

module rtbg_back import rtbg_pkg::*; #(
   parameter int unsigned TABLE_ADDR_BITS = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        pop_valid,
   output logic        pop_ready,
   input  work_type    pop_data,
   rtbg_rsp_if.source  rsp_if
);

   localparam int unsigned TAB_N = 1 << TABLE_ADDR_BITS;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_ENV   = 2'd1;
   localparam logic [1:0] S_SCALE = 2'd2;
   localparam logic [1:0] S_PROD  = 2'd3;

   typedef logic [15:0] rom_type [TAB_N];

   // shift-subtract divide for the table build
   function automatic longint unsigned div_u64(longint unsigned num, longint unsigned den);
      longint unsigned quo, rem;
      quo = '0;
      rem = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[62:0], num[i]};
         quo = {quo[62:0], 1'b0};
         if (rem >= den) begin
            rem    = rem - den;
            quo[0] = 1'b1;
         end
      end
      return quo;
   endfunction

   // quarter-wave cosine, Q30 Taylor series rounded to Q15
   function automatic rom_type build_rom();
      rom_type         rom;
      longint unsigned x, x2, term, dv, v;
      longint          sum;
      for (int unsigned k = 0; k < TAB_N; k++) begin
         x    = (HALF_PI_Q30 * longint'(k)) >> TABLE_ADDR_BITS;
         x2   = (x * x) >> 30;
         term = 64'd1 << 30;
         sum  = longint'(term);
         for (int unsigned n = 1; n <= 8; n++) begin
            dv   = longint'((2 * n - 1) * (2 * n));
            term = div_u64((term * x2) >> 30, dv);
            if (n[0]) begin
               sum = sum - longint'(term);
            end else begin
               sum = sum + longint'(term);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         v = (longint'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
         if (v > 64'd32767) begin
            v = 64'd32767;
         end
         rom[k] = 16'(v);
      end
      return rom;
   endfunction

   localparam rom_type COS_ROM = build_rom();

   logic [1:0]                 state_ff, state_in;
   logic [1:0]                 work_env_ff;
   logic [31:0]                work_tone_ph_ff;
   logic [31:0]                look_ph;
   logic [1:0]                 look_quad;
   logic [TABLE_ADDR_BITS-1:0] look_idx, look_addr;
   logic                       look_zero, look_neg;
   logic [15:0]                rom_q_ff;
   logic                       look_zero_ff, look_neg_ff;
   logic [14:0]                rom_mag;
   logic                       env_add;
   logic [16:0]                env_sum;
   logic [15:0]                env_ff, env_in;
   logic [30:0]                scale_ff;
   logic [14:0]                cmag_ff;
   logic                       cneg_ff;
   logic [45:0]                prod;
   logic [15:0]                prod_mag;
   logic [14:0]                mag;
   logic [SAMPLE_BITS-1:0]     sat_sample;
   logic                       out_free, out_load, pop;
   logic [SAMPLE_BITS-1:0]     out_sample_in;
   logic                       out_done_in;
   logic                       rsp_valid_ff;
   logic [SAMPLE_BITS-1:0]     sample_ff;
   logic                       done_ff;

   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.sample   = sample_ff;
   assign rsp_if.done_res = done_ff;
   assign out_free        = !rsp_valid_ff || rsp_if.ready;
   assign pop_ready       = pop;

   // ramp phase from the queue head, tone phase from the held work
   assign look_ph   = (state_ff == S_IDLE) ? pop_data.ramp_phase : work_tone_ph_ff;
   assign look_quad = look_ph[31:30];
   assign look_idx  = look_ph[29 -: TABLE_ADDR_BITS];
   assign look_addr = look_quad[0] ? (~look_idx + 1'b1) : look_idx;
   assign look_zero = look_quad[0] && (look_idx == '0);
   assign look_neg  = look_quad[1] ^ look_quad[0];
   assign rom_mag   = look_zero_ff ? '0 : rom_q_ff[14:0];

   always_comb begin
      env_add = ((work_env_ff == ENV_RISE) && look_neg_ff) ||
                ((work_env_ff == ENV_FALL) && !look_neg_ff);
      env_sum = env_add ? (17'd32768 + 17'(rom_mag)) : (17'd32768 - 17'(rom_mag));
      case (work_env_ff)
         ENV_RISE, ENV_FALL: env_in = env_sum[16:1];
         default:            env_in = 16'h8000;
      endcase
   end

   assign prod     = scale_ff * cmag_ff;
   assign prod_mag = prod[45:30];
   assign mag      = (prod_mag > 16'd16384) ? 15'd16384 : prod_mag[14:0];

   always_comb begin
      if (cneg_ff) begin
         sat_sample = ~mag + 1'b1;
      end else if (mag == 15'd16384) begin
         sat_sample = 15'd16383;
      end else begin
         sat_sample = mag;
      end
   end

   always_comb begin
      state_in      = state_ff;
      pop           = 1'b0;
      out_load      = 1'b0;
      out_sample_in = '0;
      out_done_in   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (pop_valid) begin
               if (pop_data.tone) begin
                  pop      = 1'b1;
                  state_in = S_ENV;
               end else if (out_free) begin
                  pop         = 1'b1;
                  out_load    = 1'b1;
                  out_done_in = pop_data.done;
               end
            end
         end
         S_ENV:   state_in = S_SCALE;
         S_SCALE: state_in = S_PROD;
         S_PROD: begin
            if (out_free) begin
               out_load      = 1'b1;
               out_sample_in = sat_sample;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rom_q_ff     <= COS_ROM[look_addr];
      look_zero_ff <= look_zero;
      look_neg_ff  <= look_neg;
      if (pop && pop_data.tone) begin
         work_env_ff     <= pop_data.env_mode;
         work_tone_ph_ff <= pop_data.tone_phase;
      end
      if (state_ff == S_ENV) begin
         env_ff <= env_in;
      end
      if (state_ff == S_SCALE) begin
         scale_ff <= AMPLITUDE * env_ff;
         cmag_ff  <= rom_mag;
         cneg_ff  <= look_neg_ff;
      end
      if (out_load) begin
         sample_ff <= out_sample_in;
         done_ff   <= out_done_in;
      end
   end

endmodule

`default_nettype wire
